[hw/rtl/crtp_pkg.sv]
// ---------------------------------------------------------------------------
// crtp_pkg: shared constants and types of the rectangular-to-polar core
// Widths, CORDIC angle table and the stage payload structures.
// ---------------------------------------------------------------------------
package crtp_pkg;

  localparam int COORD_WIDTH  = 16;
  localparam int GUARD_BITS   = 16;
  localparam int CORDIC_STEPS = 17;
  localparam int ANGLE_W      = 16;

  // CORDIC datapath: coordinate, guard bits and room for the gain and sign.
  localparam int XW = COORD_WIDTH + GUARD_BITS + 3;
  // Q16 angle accumulator; its magnitude stays below 2^18.
  localparam int ZW = 20;

  // Sum of squares and the square root datapath.
  localparam int SQ_W = 2 * COORD_WIDTH;
  localparam int SW   = 2 * COORD_WIDTH + 1;

  localparam int NUM_STAGES = (CORDIC_STEPS > COORD_WIDTH) ? CORDIC_STEPS : COORD_WIDTH;
  localparam int SHIFT_W    = $clog2(XW);
  localparam int BPOS_W     = $clog2(SW);

  localparam int ANG_PI_Q13      = 25736;
  localparam int ANG_HALF_PI_Q13 = 12868;
  localparam int ANG_HALF_PI_Q16 = 102944;

  typedef struct packed {
    logic neg_x;
    logic zero_x;
    logic zero_y;
    logic pos_y;
  } cflags_t;

  typedef struct packed {
    logic                 vld;
    cflags_t              flags;
    logic signed [XW-1:0] vx;
    logic signed [XW-1:0] vy;
    logic signed [ZW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [SW-1:0] rem;
    logic [SW-1:0] root;
  } sqrt_t;

  // round(atan(2^-i) * 2^16); zero past the last iteration.
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0:  val = ZW'(51472);
      1:  val = ZW'(30386);
      2:  val = ZW'(16055);
      3:  val = ZW'(8150);
      4:  val = ZW'(4091);
      5:  val = ZW'(2047);
      6:  val = ZW'(1024);
      7:  val = ZW'(512);
      8:  val = ZW'(256);
      9:  val = ZW'(128);
      10: val = ZW'(64);
      11: val = ZW'(32);
      12: val = ZW'(16);
      13: val = ZW'(8);
      14: val = ZW'(4);
      15: val = ZW'(2);
      16: val = ZW'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

[hw/rtl/cartesian_to_polar_core.sv]
// ---------------------------------------------------------------------------
// cartesian_to_polar_core: pipelined rectangular to polar converter
// Magnitude by a pipelined square root, angle by a pipelined CORDIC.
// ---------------------------------------------------------------------------
//   Channel   Direction  Handshake             Payload
//   in_       input      in_valid / in_stall   in_x_coord, in_y_coord
//   out_      output     out_valid / out_stall out_magnitude, out_angle
//
// One transaction enters per clock while in_stall is low. The pipeline holds
// two front stages, one stage per CORDIC iteration and square-root digit,
// side by side, and the output register.
// Reset is synchronous on rst_n and clears the valid bits only.
// While the output register holds a result that is stalled, the whole
// pipeline freezes and in_stall is raised; nothing is dropped or repeated.
// ---------------------------------------------------------------------------
module cartesian_to_polar_core import crtp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_WIDTH-1:0]        out_magnitude,
  output logic signed [ANGLE_W-1:0]     out_angle
);

  logic                       en;
  cordic_t                    cst [NUM_STAGES+1];
  sqrt_t                      sst [NUM_STAGES+1];
  logic [SQ_W-1:0]            sum;
  cordic_t                    last;
  logic signed [ZW-1:0]       z_rnd, z_clamp;
  logic signed [ANGLE_W-1:0]  angle_nxt;
  logic [SW-1:0]              root_fin;
  logic                       out_valid_r;
  logic [COORD_WIDTH-1:0]     out_magnitude_r;
  logic signed [ANGLE_W-1:0]  out_angle_r;

  assign in_stall = out_valid_r & out_stall;
  assign en       = ~in_stall;

  crtp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .x_coord (in_x_coord),
    .y_coord (in_y_coord),
    .st_out  (cst[0]),
    .sum_out (sum)
  );

  assign sst[0].rem  = {1'b0, sum};
  assign sst[0].root = '0;

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    localparam int BPOS = (k < COORD_WIDTH) ? 2 * (COORD_WIDTH - 1 - k) : 0;

    crtp_cordic_stage u_cordic (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .active   (k < CORDIC_STEPS),
      .shift    (SHIFT_W'(k)),
      .atan_val (atan_q16(k)),
      .st_in    (cst[k]),
      .st_out   (cst[k+1])
    );

    crtp_sqrt_stage u_sqrt (
      .clk    (clk),
      .en     (en),
      .active (k < COORD_WIDTH),
      .bpos   (BPOS_W'(BPOS)),
      .sq_in  (sst[k]),
      .sq_out (sst[k+1])
    );
  end

  assign last = cst[NUM_STAGES];

  always_comb begin
    z_rnd = (last.z + ZW'(4)) >>> 3;
    if (z_rnd > ZW'(ANG_PI_Q13)) begin
      z_clamp = ZW'(ANG_PI_Q13);
    end else if (z_rnd < -ZW'(ANG_PI_Q13)) begin
      z_clamp = -ZW'(ANG_PI_Q13);
    end else begin
      z_clamp = z_rnd;
    end

    // Points on the axes get exact angles instead of the CORDIC estimate.
    if (last.flags.zero_y) begin
      angle_nxt = last.flags.neg_x ? ANGLE_W'(ANG_PI_Q13) : '0;
    end else if (last.flags.zero_x) begin
      angle_nxt = last.flags.pos_y ? ANGLE_W'(ANG_HALF_PI_Q13) : -ANGLE_W'(ANG_HALF_PI_Q13);
    end else begin
      angle_nxt = z_clamp[ANGLE_W-1:0];
    end

    // The remainder is s - r*r, so rounding to nearest is one compare.
    root_fin = sst[NUM_STAGES].root
             + {{(SW-1){1'b0}}, (sst[NUM_STAGES].rem > sst[NUM_STAGES].root)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r     <= last.vld;
      out_magnitude_r <= root_fin[COORD_WIDTH-1:0];
      out_angle_r     <= angle_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_magnitude = out_magnitude_r;
  assign out_angle     = out_angle_r;

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle <= ANGLE_W'(ANG_PI_Q13)) && (out_angle >= -ANGLE_W'(ANG_PI_Q13)))
    else $error("angle outside the range of plus or minus pi");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(last.vld) && $stable(cst[0].vld))
    else $error("pipeline moved while the output was stalled");

  a_valid_follow: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> (out_valid == $past(last.vld)))
    else $error("output valid does not follow the last pipeline stage");

endmodule

[hw/rtl/crtp_front.sv]
// ---------------------------------------------------------------------------
// crtp_front: input conditioning
// Squares both coordinates, pre-rotates the vector into the right half
// plane and sums the squares, over two register stages.
// ---------------------------------------------------------------------------
module crtp_front import crtp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  output cordic_t                       st_out,
  output logic [SQ_W-1:0]               sum_out
);

  logic signed [XW-1:0]   xs, ys;
  logic signed [SQ_W-1:0] sq_x_nxt, sq_y_nxt;
  logic signed [SQ_W-1:0] sq_x_r, sq_y_r;
  cordic_t                s1_nxt, s1_r, s2_r;
  logic [SQ_W-1:0]        sum_r;

  always_comb begin
    xs = {{(XW-COORD_WIDTH-GUARD_BITS){x_coord[COORD_WIDTH-1]}}, x_coord, {GUARD_BITS{1'b0}}};
    ys = {{(XW-COORD_WIDTH-GUARD_BITS){y_coord[COORD_WIDTH-1]}}, y_coord, {GUARD_BITS{1'b0}}};
    sq_x_nxt = SQ_W'(x_coord) * SQ_W'(x_coord);
    sq_y_nxt = SQ_W'(y_coord) * SQ_W'(y_coord);

    s1_nxt.vld          = in_vld;
    s1_nxt.flags.neg_x  = x_coord[COORD_WIDTH-1];
    s1_nxt.flags.zero_x = (x_coord == '0);
    s1_nxt.flags.zero_y = (y_coord == '0);
    s1_nxt.flags.pos_y  = !y_coord[COORD_WIDTH-1] && (y_coord != '0);
    s1_nxt.vx = xs;
    s1_nxt.vy = ys;
    s1_nxt.z  = '0;
    // Vectors in the left half plane are turned by a quarter turn first.
    if (x_coord[COORD_WIDTH-1]) begin
      if (!y_coord[COORD_WIDTH-1]) begin
        s1_nxt.vx = ys;
        s1_nxt.vy = -xs;
        s1_nxt.z  = ZW'(ANG_HALF_PI_Q16);
      end else begin
        s1_nxt.vx = -ys;
        s1_nxt.vy = xs;
        s1_nxt.z  = -ZW'(ANG_HALF_PI_Q16);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else if (en) begin
      s1_r   <= s1_nxt;
      sq_x_r <= sq_x_nxt;
      sq_y_r <= sq_y_nxt;
      s2_r   <= s1_r;
      sum_r  <= sq_x_r + sq_y_r;
    end
  end

  assign st_out  = s2_r;
  assign sum_out = sum_r;

endmodule

[hw/rtl/crtp_cordic_stage.sv]
// ---------------------------------------------------------------------------
// crtp_cordic_stage: one registered CORDIC vectoring iteration
// Drives y toward zero and accumulates the rotation angle.
// ---------------------------------------------------------------------------
module crtp_cordic_stage import crtp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 active,
  input  logic [SHIFT_W-1:0]   shift,
  input  logic signed [ZW-1:0] atan_val,
  input  cordic_t              st_in,
  output cordic_t              st_out
);

  logic signed [XW-1:0] vx, vy, dx, dy;
  logic signed [ZW-1:0] z;
  cordic_t              st_nxt, st_r;

  always_comb begin
    vx = st_in.vx;
    vy = st_in.vy;
    z  = st_in.z;
    dx = vy >>> shift;
    dy = vx >>> shift;
    st_nxt = st_in;
    if (active) begin
      if (!vy[XW-1]) begin
        st_nxt.vx = vx + dx;
        st_nxt.vy = vy - dy;
        st_nxt.z  = z + atan_val;
      end else begin
        st_nxt.vx = vx - dx;
        st_nxt.vy = vy + dy;
        st_nxt.z  = z - atan_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.vld <= 1'b0;
    end else if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_out = st_r;

endmodule

[hw/rtl/crtp_sqrt_stage.sv]
// ---------------------------------------------------------------------------
// crtp_sqrt_stage: one registered digit of the integer square root
// Restoring digit-by-digit step that settles one result bit.
// ---------------------------------------------------------------------------
module crtp_sqrt_stage import crtp_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic              active,
  input  logic [BPOS_W-1:0] bpos,
  input  sqrt_t             sq_in,
  output sqrt_t             sq_out
);

  logic [SW-1:0] bit_val, trial;
  sqrt_t         sq_nxt, sq_r;

  always_comb begin
    bit_val = {{(SW-1){1'b0}}, 1'b1} << bpos;
    trial   = sq_in.root + bit_val;
    sq_nxt  = sq_in;
    if (active) begin
      if (sq_in.rem >= trial) begin
        sq_nxt.rem  = sq_in.rem - trial;
        sq_nxt.root = (sq_in.root >> 1) + bit_val;
      end else begin
        sq_nxt.root = sq_in.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_out = sq_r;

endmodule

[tb/sv/polar_checker.sv]
// ---------------------------------------------------------------------------
// polar_checker: result checker for the rectangular-to-polar core
// Watches both channels, works out the magnitude and angle of every accepted
// point and compares each accepted result with the oldest one outstanding.
// ---------------------------------------------------------------------------
module polar_checker import crtp_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_x_coord,
  input  logic signed [COORD_WIDTH-1:0] in_y_coord,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [COORD_WIDTH-1:0]        out_magnitude,
  input  logic signed [ANGLE_W-1:0]     out_angle,
  output int                            mismatches,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_WIDTH-1:0]    magnitude;
    logic signed [ANGLE_W-1:0] angle;
  } polar_t;

  // round(atan(2^-i) * 2^16) for each vectoring iteration.
  localparam longint ATAN_Q16 [CORDIC_STEPS] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
    128, 64, 32, 16, 8, 4, 2, 1
  };

  polar_t polar_due[$];

  function automatic polar_t polar_of(input logic signed [COORD_WIDTH-1:0] x,
                                      input logic signed [COORD_WIDTH-1:0] y);
    longint ax, ay, sq, root, cand, vx, vy, z, dx, dy;
    polar_t res;
    ax = (x < 0) ? -longint'(x) : longint'(x);
    ay = (y < 0) ? -longint'(y) : longint'(y);
    sq = ax * ax + ay * ay;
    root = 0;
    for (int b = COORD_WIDTH; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= sq) root = cand;
    end
    // Round to nearest: step up when the remainder exceeds the root.
    if (sq - root * root > root) root = root + 1;
    res.magnitude = root[COORD_WIDTH-1:0];

    if (y == 0) begin
      z = (x < 0) ? ANG_PI_Q13 : 0;
    end else if (x == 0) begin
      z = (y > 0) ? ANG_HALF_PI_Q13 : -ANG_HALF_PI_Q13;
    end else begin
      vx = longint'(x) <<< GUARD_BITS;
      vy = longint'(y) <<< GUARD_BITS;
      z = 0;
      // Left half plane: rotate by a quarter turn into the right half first.
      if (x < 0) begin
        dx = vx;
        if (y >= 0) begin
          vx = vy;
          vy = -dx;
          z = ANG_HALF_PI_Q16;
        end else begin
          vx = -vy;
          vy = dx;
          z = -ANG_HALF_PI_Q16;
        end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy >= 0) begin
          vx = vx + dx;
          vy = vy - dy;
          z = z + ATAN_Q16[i];
        end else begin
          vx = vx - dx;
          vy = vy + dy;
          z = z - ATAN_Q16[i];
        end
      end
      z = (z + 4) >>> 3;
      if (z > ANG_PI_Q13) z = ANG_PI_Q13;
      if (z < -ANG_PI_Q13) z = -ANG_PI_Q13;
    end
    res.angle = z[ANGLE_W-1:0];
    return res;
  endfunction

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    polar_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (polar_due.size() == 0) begin
          $error("unexpected result transaction: magnitude %0d angle %0d",
                 out_magnitude, out_angle);
          mismatches++;
        end else begin
          want = polar_due.pop_front();
          if (out_magnitude !== want.magnitude) begin
            $error("magnitude: expected %0d, actual %0d", want.magnitude, out_magnitude);
            mismatches++;
          end
          if (out_angle !== want.angle) begin
            $error("angle: expected %0d, actual %0d", want.angle, out_angle);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) polar_due.push_back(polar_of(in_x_coord, in_y_coord));
      outstanding = polar_due.size();
    end
  end

endmodule

[tb/sv/cartesian_to_polar_core_tb.sv]
// ---------------------------------------------------------------------------
// cartesian_to_polar_core_tb: regression bench of the rectangular-to-polar core
// Directed corner points, then bursts of random points under random
// back-pressure, with one long output hold-off and one full drain.
// ---------------------------------------------------------------------------
module cartesian_to_polar_core_tb import crtp_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY        = NUM_STAGES + 3;
  localparam int RANDOM_ITEMS   = 1250;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIRECTED     = 22;

  localparam shortint DIR_X [N_DIRECTED] = '{
    0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1, -1,
    0, 0, 1, -1, -1, 1, -32768, -32768, -1, 32767, -32767
  };
  localparam shortint DIR_Y [N_DIRECTED] = '{
    0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 0, 0,
    1, -1, 1, -1, 1, -1, -1, 1, -32768, 1, -32767
  };
  localparam shortint EDGE_VALS [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] in_x_coord;
  logic signed [COORD_WIDTH-1:0] in_y_coord;
  logic                          out_valid;
  logic                          out_stall;
  logic [COORD_WIDTH-1:0]        out_magnitude;
  logic signed [ANGLE_W-1:0]     out_angle;

  int mismatches;
  int outstanding;
  int quiet_cycles;
  bit hold_go;

  cartesian_to_polar_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_angle     (out_angle)
  );

  polar_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_magnitude (out_magnitude),
    .out_angle     (out_angle),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called just after a falling edge; returns just after the falling edge
  // that follows the transaction.
  task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y);
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  // Mix of full-range values, small values near the origin, edge values and
  // zero, so that axes and the origin come up often.
  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return COORD_WIDTH'($urandom);
    if (r < 75) return COORD_WIDTH'($signed($urandom_range(0, 16)) - 8);
    if (r < 88) return EDGE_VALS[$urandom_range(0, 6)];
    return '0;
  endfunction

  initial begin : stimulus
    int sent;
    int burst;
    int gap;
    bit held;
    bit paused;
    in_valid   = 1'b0;
    in_x_coord = '0;
    in_y_coord = '0;
    rst_n      = 1'b0;
    hold_go    = 1'b0;
    held       = 1'b0;
    paused     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < N_DIRECTED; k++) send_point(DIR_X[k], DIR_Y[k]);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 400 && !held) begin
        // Keep offering points while the receiver holds off, so the
        // pipeline fills and the input stalls.
        held = 1'b1;
        hold_go = 1'b1;
        repeat (90) send_point(pick_coord(), pick_coord());
        sent += 90;
      end
      if (sent >= 800 && !paused) begin
        paused = 1'b1;
        drain_results();
      end
      burst = $urandom_range(1, 48);
      repeat (burst) send_point(pick_coord(), pick_coord());
      sent += burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end

    drain_results();
    repeat (2 * LATENCY) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver back-pressure: segments of free flow, light or heavy random
  // stalls and periodic stalls, plus one long hold-off on request.
  initial begin : receiver
    int mode;
    int span;
    int period;
    out_stall = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(64, 256);
      period = $urandom_range(2, 7);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        if (hold_go) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          hold_go = 1'b0;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 99) < 30);
            2: out_stall <= ($urandom_range(0, 99) < 70);
            default: out_stall <= ((k % period) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
